@@ sv/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants
// Widths and sequencer states of the triangle tangent/binormal core.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

  localparam int CoordWidth  = 32;                 // Q16.16 coordinates
  localparam int OutFracBits = 30;                 // Q2.30 results
  localparam int OutWidth    = OutFracBits + 2;
  localparam int DeltaWidth  = CoordWidth + 1;     // difference of two coordinates
  localparam int ProdWidth   = 2 * DeltaWidth;     // one signed product
  localparam int AccWidth    = ProdWidth + 2;      // difference of two products
  localparam int MagWidth    = AccWidth - 1;       // magnitude of an accumulator
  localparam int InDataWidth  = 5 * CoordWidth;
  localparam int OutDataWidth = 6 * OutWidth;
  localparam int NumProducts  = 14;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_LOAD,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DIV,
    ST_ROUND,
    ST_DONE
  } state_e;

endpackage : ttb_pkg

`default_nettype wire

@@ sv/triangle_tangent_binormal_core.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_core
// Tangent and binormal per triangle from a stream of textured vertices.
// ----------------------------------------------------------------------------
// Every third vertex (phase restarts after tlast) closes a triangle and yields
// one transfer with the unit tangent and binormal in Q2.30 and a degenerate
// flag in tuser (vectors zero when the texture determinant or a vector is
// zero). First and second vertices are only stored. A closing vertex occupies
// the core through these steps: the fourteen products through the single
// 33x33 multiplier, then per vector a load step, one-bit normalizing shifts,
// the squares, 32 square-root steps and 3 x 31 restoring-division steps with
// a rounding step each, and a final step to place the result. A zero
// determinant skips the vectors. All of it runs on one shared multiplier, so
// s_axis_tready stays low until the result is placed in the output register;
// that register then waits for m_axis_tready while new vertices are taken.
`default_nettype none

module triangle_tangent_binormal_core
  import ttb_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output      logic                    s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  input  wire logic                    s_axis_tlast,   // end_of_mesh
  output      logic                    m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
  output      logic [OutDataWidth-1:0] m_axis_tdata,
  output      logic                    m_axis_tuser    // degenerate
);

  state_e state_q, state_d;

  logic [1:0]                  phase_q;
  logic [CoordWidth-1:0]       v0_q [5];
  logic [CoordWidth-1:0]       v1_q [5];
  logic signed [DeltaWidth-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DeltaWidth-1:0] e1_q [3];
  logic signed [DeltaWidth-1:0] e2_q [3];
  logic signed [ProdWidth-1:0]  prod_q;
  logic signed [AccWidth-1:0]   det_q;
  logic signed [AccWidth-1:0]   vec_q [6];
  logic [MagWidth-1:0]          mag_q [3];
  logic [2:0]                   neg_q;
  logic [3:0]                   idx_q;
  logic [4:0]                   cnt_q;
  logic [1:0]                   comp_q;
  logic                         vsel_q;
  logic [63:0]                  sum_q;
  logic [63:0]                  res_q;
  logic [63:0]                  bit_q;
  logic [34:0]                  rem_q;
  logic [OutWidth-1:0]          q_q;
  logic [OutWidth-1:0]          out_q [6];
  logic                         degen_q;
  logic                         out_valid_q;

  logic                         in_xfer, close_tri;
  logic signed [DeltaWidth-1:0] mul_a, mul_b;
  logic signed [AccWidth-1:0]   prod_ext, acc_tgt, acc_new;
  logic [2:0]                   pair;
  logic [MagWidth-1:0]          mag_or;
  logic [63:0]                  sq_trial;
  logic [32:0]                  len;
  logic [34:0]                  div_r;
  logic                         div_ge;
  logic [OutWidth-1:0]          q_rnd, q_sgn;
  logic [2:0]                   res_idx;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign close_tri     = in_xfer && (phase_q == 2'd2);
  assign m_axis_tvalid = out_valid_q;

  assign pair     = idx_q[3:1];
  assign prod_ext = AccWidth'(prod_q);
  assign mag_or   = mag_q[0] | mag_q[1] | mag_q[2];
  assign sq_trial = res_q + bit_q;
  assign len      = res_q[32:0];
  assign div_r    = (cnt_q == 5'd0) ? rem_q : {rem_q[33:0], 1'b0};
  assign div_ge   = div_r >= {2'b00, len};
  assign q_rnd    = q_q + OutWidth'({rem_q[33:0], 1'b0} >= {2'b00, len});
  assign q_sgn    = neg_q[comp_q] ? (~q_rnd + 1'b1) : q_rnd;
  assign res_idx  = vsel_q ? (3'd3 + 3'(comp_q)) : 3'(comp_q);

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_tgt = det_q;
    if (state_q == ST_MUL || state_q == ST_ACC) begin
      unique case (pair)
        3'd0: begin
          mul_a = idx_q[0] ? du2_q : du1_q;
          mul_b = idx_q[0] ? dv1_q : dv2_q;
          acc_tgt = det_q;
        end
        3'd1, 3'd2, 3'd3: begin
          mul_a = idx_q[0] ? dv1_q : dv2_q;
          mul_b = idx_q[0] ? e2_q[2'(pair - 3'd1)] : e1_q[2'(pair - 3'd1)];
          acc_tgt = vec_q[pair - 3'd1];
        end
        3'd4, 3'd5, 3'd6: begin
          mul_a = idx_q[0] ? du2_q : du1_q;
          mul_b = idx_q[0] ? e1_q[2'(pair - 3'd4)] : e2_q[2'(pair - 3'd4)];
          acc_tgt = vec_q[pair - 3'd1];
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
          acc_tgt = det_q;
        end
      endcase
    end else begin
      mul_a = $signed({2'b00, mag_q[cnt_q[1:0]][30:0]});
      mul_b = $signed({2'b00, mag_q[cnt_q[1:0]][30:0]});
    end
    acc_new = idx_q[0] ? (acc_tgt - prod_ext) : prod_ext;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (close_tri) state_d = ST_MUL;
      ST_MUL:    state_d = ST_ACC;
      ST_ACC: begin
        if (idx_q != 4'(NumProducts - 1)) state_d = ST_MUL;
        else if (det_q == '0)             state_d = ST_DONE;
        else                              state_d = ST_LOAD;
      end
      ST_LOAD:   state_d = ST_NORM;
      ST_NORM: begin
        if (mag_or == '0)                  state_d = ST_DONE;
        else if (!(|mag_or[MagWidth-1:31]) && mag_or[30]) state_d = ST_SQ_MUL;
      end
      ST_SQ_MUL: state_d = ST_SQ_ACC;
      ST_SQ_ACC: state_d = (cnt_q == 5'd2) ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT:   if (bit_q == 64'd1) state_d = ST_DIV;
      ST_DIV:    if (cnt_q == 5'(OutFracBits)) state_d = ST_ROUND;
      ST_ROUND: begin
        if (comp_q != 2'd2) state_d = ST_DIV;
        else if (!vsel_q)   state_d = ST_LOAD;
        else                state_d = ST_DONE;
      end
      ST_DONE:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        if (s_axis_tlast || phase_q == 2'd2) phase_q <= 2'd0;
        else                                  phase_q <= phase_q + 2'd1;
      end
      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
      else if (m_axis_tready)                                   out_valid_q <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && phase_q == 2'd0) begin
          for (int i = 0; i < 5; i++) v0_q[i] <= s_axis_tdata[i*CoordWidth +: CoordWidth];
        end
        if (in_xfer && phase_q == 2'd1) begin
          for (int i = 0; i < 5; i++) v1_q[i] <= s_axis_tdata[i*CoordWidth +: CoordWidth];
        end
        if (close_tri) begin
          du1_q <= $signed({v1_q[3][CoordWidth-1], v1_q[3]})
                 - $signed({v0_q[3][CoordWidth-1], v0_q[3]});
          dv1_q <= $signed({v1_q[4][CoordWidth-1], v1_q[4]})
                 - $signed({v0_q[4][CoordWidth-1], v0_q[4]});
          du2_q <= $signed({s_axis_tdata[4*CoordWidth-1], s_axis_tdata[3*CoordWidth +: CoordWidth]})
                 - $signed({v0_q[3][CoordWidth-1], v0_q[3]});
          dv2_q <= $signed({s_axis_tdata[5*CoordWidth-1], s_axis_tdata[4*CoordWidth +: CoordWidth]})
                 - $signed({v0_q[4][CoordWidth-1], v0_q[4]});
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= $signed({v1_q[i][CoordWidth-1], v1_q[i]})
                     - $signed({v0_q[i][CoordWidth-1], v0_q[i]});
            e2_q[i] <= $signed({s_axis_tdata[(i+1)*CoordWidth-1],
                                s_axis_tdata[i*CoordWidth +: CoordWidth]})
                     - $signed({v0_q[i][CoordWidth-1], v0_q[i]});
          end
          idx_q   <= '0;
          degen_q <= 1'b0;
          vsel_q  <= 1'b0;
        end
      end
      ST_MUL: prod_q <= mul_a * mul_b;
      ST_ACC: begin
        if (pair == 3'd0) det_q <= acc_new;
        else              vec_q[pair - 3'd1] <= acc_new;
        idx_q <= idx_q + 4'd1;
        if (idx_q == 4'(NumProducts - 1) && det_q == '0) degen_q <= 1'b1;
      end
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= vec_q[(vsel_q ? 3 : 0) + i][AccWidth-1]
                    ? MagWidth'(-vec_q[(vsel_q ? 3 : 0) + i])
                    : MagWidth'(vec_q[(vsel_q ? 3 : 0) + i]);
          neg_q[i] <= vec_q[(vsel_q ? 3 : 0) + i][AccWidth-1] ^ det_q[AccWidth-1];
        end
      end
      ST_NORM: begin
        cnt_q <= '0;
        sum_q <= '0;
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
        if (mag_or == '0) begin
          degen_q <= 1'b1;
        end else if (|mag_or[MagWidth-1:31]) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (!mag_or[30]) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
      end
      ST_SQ_MUL: prod_q <= mul_a * mul_b;
      ST_SQ_ACC: begin
        sum_q <= sum_q + prod_q[63:0];
        cnt_q <= cnt_q + 5'd1;
      end
      ST_SQRT: begin
        if (sum_q >= sq_trial) begin
          sum_q <= sum_q - sq_trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q  <= bit_q >> 2;
        cnt_q  <= '0;
        comp_q <= '0;
        rem_q  <= {4'b0, mag_q[0][30:0]};
        q_q    <= '0;
      end
      ST_DIV: begin
        rem_q <= div_ge ? (div_r - {2'b00, len}) : div_r;
        q_q   <= {q_q[OutWidth-2:0], div_ge};
        cnt_q <= cnt_q + 5'd1;
      end
      ST_ROUND: begin
        out_q[res_idx] <= q_sgn;
        cnt_q <= '0;
        q_q   <= '0;
        if (comp_q != 2'd2) begin
          comp_q <= comp_q + 2'd1;
          rem_q  <= {4'b0, mag_q[comp_q + 2'd1][30:0]};
        end else begin
          vsel_q <= 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          for (int i = 0; i < 6; i++) begin
            m_axis_tdata[i*OutWidth +: OutWidth] <= degen_q ? '0 : out_q[i];
          end
          m_axis_tuser <= degen_q;
        end
      end
      default: ;
    endcase
  end

endmodule : triangle_tangent_binormal_core

`default_nettype wire

@@ sv/ttb_checker.sv @@
// ----------------------------------------------------------------------------
// ttb_core_assert: port-level checks
// Watches the result stream of the tangent/binormal core.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_core_assert
  import ttb_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tready,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata,
  input wire logic                    m_axis_tuser
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Degenerate triangles carry zero vectors.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero vectors");

  // The tangent x component stays within one.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[OutWidth-1:0]) <= $signed(OutWidth'(1) << OutFracBits))
      && ($signed(m_axis_tdata[OutWidth-1:0]) >= -$signed(OutWidth'(1) << OutFracBits)))
    else $error("tangent x outside unit range");

  // A result appears only after the core has been busy on a vertex.
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without a busy interval");

endmodule : ttb_core_assert

bind triangle_tangent_binormal_core ttb_core_assert u_ttb_core_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/sv/ttb_checker.sv @@
// ----------------------------------------------------------------------------
// ttb_checker: tangent/binormal scoreboard
// Watches both stream channels, predicts one result per closing vertex with
// exact integer math, and compares every output transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_checker
  import ttb_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  input  wire logic                    s_axis_tready,
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  input  wire logic                    s_axis_tlast,
  input  wire logic                    m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  input  wire logic [OutDataWidth-1:0] m_axis_tdata,
  input  wire logic                    m_axis_tuser,
  output int                           fails_o,
  output int                           pending_o,
  output int                           results_o,
  output int                           degenerate_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [5:0][OutWidth-1:0] vec;   // tangent x,y,z then binormal x,y,z
    logic                     degen;
  } basis_t;

  basis_t                        basis_q[$];
  logic [1:0]                    tri_phase;
  logic signed [CoordWidth-1:0]  vtx_a [5];
  logic signed [CoordWidth-1:0]  vtx_b [5];

  assign pending_o = basis_q.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bit_v;
    res   = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x   = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // Scale to a 31-bit leading magnitude, then divide each component by length.
  function automatic bit unit_vector(input wide_t c0, input wide_t c1, input wide_t c2,
                                     output logic [2:0][OutWidth-1:0] res);
    wide_t       comp [3];
    wide_t       mag [3];
    logic [63:0] m [3];
    logic [63:0] sum, len, rem, q;
    int          top;
    comp[0] = c0; comp[1] = c1; comp[2] = c2;
    top = 0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
      for (int b = 127; b >= 0; b--)
        if (mag[i][b] && b + 1 > top) top = b + 1;
    end
    if (top == 0) return 1'b0;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (top > 31) m[i] = 64'(mag[i] >> (top - 31));
      else          m[i] = 64'(mag[i] << (31 - top));
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      rem = m[i];
      q   = '0;
      if (rem >= len) begin q = 1; rem -= len; end
      for (int k = 0; k < OutFracBits; k++) begin
        rem <<= 1; q <<= 1;
        if (rem >= len) begin rem -= len; q |= 1; end
      end
      rem <<= 1;
      if (rem >= len) q += 1;
      res[i] = OutWidth'(comp[i] < 0 ? -q : q);
    end
    return 1'b1;
  endfunction

  function automatic basis_t close_triangle(input logic [InDataWidth-1:0] cur_bits);
    logic signed [CoordWidth-1:0] cur [5];
    longint                       du1, dv1, du2, dv2;
    longint                       e1 [3];
    longint                       e2 [3];
    wide_t                        det;
    wide_t                        tan_v [3];
    wide_t                        bin_v [3];
    logic [2:0][OutWidth-1:0]     tan_o, bin_o;
    basis_t                       r;
    bit                           ok;
    for (int i = 0; i < 5; i++) cur[i] = cur_bits[i*CoordWidth +: CoordWidth];
    du1 = longint'(vtx_b[3]) - longint'(vtx_a[3]);
    dv1 = longint'(vtx_b[4]) - longint'(vtx_a[4]);
    du2 = longint'(cur[3]) - longint'(vtx_a[3]);
    dv2 = longint'(cur[4]) - longint'(vtx_a[4]);
    det = wide_t'(du1) * wide_t'(dv2) - wide_t'(du2) * wide_t'(dv1);
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(vtx_b[i]) - longint'(vtx_a[i]);
      e2[i] = longint'(cur[i]) - longint'(vtx_a[i]);
      tan_v[i] = wide_t'(dv2) * wide_t'(e1[i]) - wide_t'(dv1) * wide_t'(e2[i]);
      bin_v[i] = wide_t'(du1) * wide_t'(e2[i]) - wide_t'(du2) * wide_t'(e1[i]);
      if (det < 0) begin
        tan_v[i] = -tan_v[i];
        bin_v[i] = -bin_v[i];
      end
    end
    ok = det != 0;
    if (ok) ok = unit_vector(tan_v[0], tan_v[1], tan_v[2], tan_o);
    if (ok) ok = unit_vector(bin_v[0], bin_v[1], bin_v[2], bin_o);
    r = '0;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        r.vec[i]     = tan_o[i];
        r.vec[3 + i] = bin_o[i];
      end
    end
    r.degen = !ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [OutWidth-1:0] got,
                                 input logic [OutWidth-1:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fails_o++;
  endtask

  initial begin
    fails_o      = 0;
    results_o    = 0;
    degenerate_o = 0;
    tri_phase    = '0;
  end

  always @(posedge clk_i) begin
    basis_t exp_b;
    basis_t got_b;
    if (rst_ni) begin
      // Retire before predicting so a same-edge result meets the older entry.
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        got_b.vec   = m_axis_tdata;
        got_b.degen = m_axis_tuser;
        if (basis_q.size() == 0) begin
          report_mismatch("unexpected result", got_b.vec[0], '0);
        end else begin
          exp_b = basis_q.pop_front();
          if (exp_b.degen) degenerate_o++;
          for (int i = 0; i < 6; i++)
            if (got_b.vec[i] !== exp_b.vec[i])
              report_mismatch($sformatf("%s_%s", i < 3 ? "tangent" : "binormal",
                              i % 3 == 0 ? "x" : i % 3 == 1 ? "y" : "z"),
                              got_b.vec[i], exp_b.vec[i]);
          if (got_b.degen !== exp_b.degen)
            report_mismatch("degenerate", OutWidth'(got_b.degen), OutWidth'(exp_b.degen));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (tri_phase)
          2'd0: begin
            for (int i = 0; i < 5; i++) vtx_a[i] = s_axis_tdata[i*CoordWidth +: CoordWidth];
            tri_phase = 2'd1;
          end
          2'd1: begin
            for (int i = 0; i < 5; i++) vtx_b[i] = s_axis_tdata[i*CoordWidth +: CoordWidth];
            tri_phase = 2'd2;
          end
          default: begin
            basis_q = {basis_q, close_triangle(s_axis_tdata)};
            tri_phase = 2'd0;
          end
        endcase
        if (s_axis_tlast) tri_phase = 2'd0;
      end
    end
  end

endmodule : ttb_checker

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: triangle tangent/binormal core
// Streams directed and random triangles through the core under varied valid
// and ready gaps, and lets the checker score every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ttb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 40000;
  localparam int DrainCycles   = 600;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tuser;

  int fails, pending, results, degenerates;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;
  int vertices_sent;
  int idle_count;

  triangle_tangent_binormal_core u_top (.*);

  ttb_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fails_o(fails), .pending_o(pending), .results_o(results),
    .degenerate_o(degenerates)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    idle_count = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_count = 0;
      else
        idle_count++;
      if (idle_count >= WatchdogLimit) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [31:0] u,
                             input logic signed [31:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, u, z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    vertices_sent++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(8192)) - 4096) <<< 12;
      2:       return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(255)
                                        : 32'h8000_0000 + $urandom_range(255);
      3:       return 32'($signed($urandom_range(64)) - 32);
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19)) <<< 8;
    endcase
  endfunction

  task automatic send_random_vertex(input logic last);
    send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), last);
  endtask

  // Mostly full triangles; some with shared texture coordinates, some broken.
  task automatic random_traffic(input int count);
    int sent;
    logic [31:0] u0, v0;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(19))
        0, 1: begin
          send_random_vertex($urandom_range(1));
          sent++;
        end
        2: begin
          u0 = rand_coord(); v0 = rand_coord();
          send_vertex(rand_coord(), rand_coord(), rand_coord(), u0, v0, 1'b0);
          send_vertex(rand_coord(), rand_coord(), rand_coord(), u0, v0, 1'b0);
          send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(3) == 0);
          sent += 3;
        end
        default: begin
          send_random_vertex(1'b0);
          send_random_vertex(1'b0);
          send_random_vertex($urandom_range(7) == 0);
          sent += 3;
        end
      endcase
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    vertices_sent  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unit right triangle, extremes, zero determinant, zero tangent,
    // short mesh ends after one and two vertices.
    send_vertex(0, 0, 0, 0, 0, 1'b0);
    send_vertex(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0);
    send_vertex(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                1'b0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                1'b0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                1'b1);
    send_vertex(1, 2, 3, 5, 5, 1'b0);
    send_vertex(4, 5, 6, 5, 5, 1'b0);
    send_vertex(7, 9, 8, 5, 5, 1'b0);
    send_vertex(9, 9, 9, 0, 0, 1'b0);
    send_vertex(9, 9, 9, 32'h0002_0000, 0, 1'b0);
    send_vertex(9, 9, 9, 0, 32'h0003_0000, 1'b0);
    send_vertex(1, 1, 1, 1, 1, 1'b1);
    send_vertex(2, 2, 2, 2, 2, 1'b0);
    send_vertex(3, 3, 3, 3, 3, 1'b1);
    send_vertex(32'hffff_ffff, 0, 0, 0, 0, 1'b0);
    send_vertex(0, 32'hffff_ffff, 0, 32'hffff_ffff, 0, 1'b0);
    send_vertex(0, 0, 32'hffff_ffff, 0, 32'hffff_ffff, 1'b1);

    random_traffic(210);
    send_idle_pct = 69;
    random_traffic(210);
    send_idle_pct = 0; recv_stall_pct = 69;
    random_traffic(210);
    send_idle_pct = 6; recv_stall_pct = 6;
    random_traffic(150);

    // Hold the output for a long stretch while vertices keep coming.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_cycles = 3000;
    random_traffic(30);
    stop_sending();
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    random_traffic(60);
    stop_sending();

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d vertices, checked %0d triangle results (%0d degenerate)",
             vertices_sent, results, degenerates);
    $display("mismatches: %0d", fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire

@@ filelist.f @@
sv/ttb_pkg.sv
sv/triangle_tangent_binormal_core.sv
sv/ttb_checker.sv
tb/sv/ttb_checker.sv
tb/sv/testbench.sv
